>>> hdl/uerm_pkg.sv
// Package for the ultrasonic echo range meter.
// Holds the event codes, flag bit positions, register indexes and reset values.
// No dependencies.
package uerm_pkg;

  localparam int TIMER_BITS_DEF = 8;

  localparam int CMD_W     = 3;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 6;
  localparam int SHIFT_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_RISE  = 3'd1,
    CMD_FALL  = 3'd2,
    CMD_TRIG  = 3'd3,
    CMD_READ  = 3'd4,
    CMD_ADC   = 3'd5
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_OVF_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MULT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHFT = 2'd2;

  localparam int F_BUSY   = 0;
  localparam int F_ECHOHI = 1;
  localparam int F_ECHOLO = 2;
  localparam int F_NEW    = 3;
  localparam int F_OVF    = 4;
  localparam int F_ERR    = 5;

  // Busy, echo high, echo low and new-data: the bits an aborted measurement drops.
  localparam logic [STATUS_W-1:0] ABORT_MASK = 6'b00_1111;

  localparam logic [BYTE_W-1:0]  OVF_LIMIT_RST  = 8'd20;
  localparam logic [BYTE_W-1:0]  SCALE_MULT_RST = 8'd34;
  localparam logic [SHIFT_W-1:0] SCALE_SHFT_RST = 4'd5;

endpackage

>>> hdl/uerm_if.sv
// Valid/ready channel interfaces for the echo range meter: event input and result output.
// Depends on uerm_pkg for field widths.
interface uerm_in_if;
  logic                           valid;
  logic                           ready;
  logic [uerm_pkg::CMD_W-1:0]     cmd;
  logic [uerm_pkg::BYTE_W-1:0]    adc_value;

  modport source (output valid, cmd, adc_value, input ready);
  modport sink   (input valid, cmd, adc_value, output ready);
endinterface

interface uerm_out_if;
  logic                           valid;
  logic                           ready;
  logic [uerm_pkg::STATUS_W-1:0]  status;
  logic [uerm_pkg::BYTE_W-1:0]    range_high;
  logic [uerm_pkg::BYTE_W-1:0]    range_low;
  logic [uerm_pkg::BYTE_W-1:0]    infrared_value;
  logic                           read_valid;
  logic                           trigger_start;

  modport source (output valid, status, range_high, range_low, infrared_value,
                  read_valid, trigger_start, input ready);
  modport sink   (input valid, status, range_high, range_low, infrared_value,
                  read_valid, trigger_start, output ready);
endinterface

>>> hdl/ultrasonic_echo_range_meter.sv
// Ultrasonic echo range meter: event decoding, timer, overflow check and range scaling.
// Depends on uerm_pkg and the channel interfaces in uerm_if.sv.
// The result of an accepted item is registered in the output register.
// Throughput: one item per cycle; the whole event is handled by one pass of logic
// from the state registers into the result register, and a new item is taken
// whenever the output register is empty or being emptied in the same cycle.
// Reset (synchronous, active low) clears all flags, counters, latched range and
// infrared sample, and loads the register defaults; no clearing pass is needed.
module ultrasonic_echo_range_meter #(
  parameter int TIMER_BITS = uerm_pkg::TIMER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  uerm_in_if.sink                           in_ch,
  uerm_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [uerm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [uerm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int BW     = uerm_pkg::BYTE_W;
  localparam int SW     = uerm_pkg::STATUS_W;
  localparam int RAW_W  = BW + TIMER_BITS;
  localparam int PROD_W = RAW_W + BW;

  // Configuration registers
  logic [BW-1:0]                  ovf_limit_r;
  logic [BW-1:0]                  scale_mult_r;
  logic [uerm_pkg::SHIFT_W-1:0]   scale_shft_r;

  // Measurement state
  logic [SW-1:0]         flag_r, flag_nxt;
  logic [TIMER_BITS-1:0] tick_r, tick_nxt;
  logic [BW-1:0]         ovf_cnt_r, ovf_cnt_nxt;
  logic [BW-1:0]         lat_hi_r, lat_hi_nxt;
  logic [BW-1:0]         lat_lo_r, lat_lo_nxt;
  logic [BW-1:0]         ir_r, ir_nxt;

  // Result register
  logic                  out_valid_r;
  logic [SW-1:0]         status_r, status_nxt;
  logic                  read_valid_r, read_valid_nxt;
  logic                  trig_r, trig_nxt;

  logic                  in_acc;
  logic                  running;
  logic [TIMER_BITS-1:0] tick_inc;
  logic [BW:0]           ovf_inc;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     scaled;
  logic [15:0]           range_sat;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign running  = flag_r[uerm_pkg::F_BUSY] && flag_r[uerm_pkg::F_ECHOHI]
                    && !flag_r[uerm_pkg::F_ECHOLO];
  assign tick_inc = tick_r + TIMER_BITS'(1);
  assign ovf_inc  = {1'b0, ovf_cnt_r} + (BW+1)'(1);

  // Raw count is {overflows, ticks}; the product is kept wide so it never wraps.
  assign prod      = PROD_W'({ovf_cnt_r, tick_r}) * PROD_W'(scale_mult_r);
  assign scaled    = prod >> scale_shft_r;
  assign range_sat = (|scaled[PROD_W-1:16]) ? 16'hFFFF : scaled[15:0];

  always_comb begin
    flag_nxt       = flag_r;
    tick_nxt       = tick_r;
    ovf_cnt_nxt    = ovf_cnt_r;
    lat_hi_nxt     = lat_hi_r;
    lat_lo_nxt     = lat_lo_r;
    ir_nxt         = ir_r;
    read_valid_nxt = 1'b0;
    trig_nxt       = 1'b0;
    case (in_ch.cmd)
      uerm_pkg::CMD_TICK: begin
        tick_nxt = tick_inc;
        if (tick_inc == '0) begin
          if (running) begin
            // The limit is checked on the incremented count, so 255 still trips.
            if (ovf_inc > {1'b0, ovf_limit_r}) begin
              flag_nxt = (flag_r & ~uerm_pkg::ABORT_MASK);
              flag_nxt[uerm_pkg::F_OVF] = 1'b1;
            end
            ovf_cnt_nxt = ovf_inc[BW] ? {BW{1'b1}} : ovf_inc[BW-1:0];
          end else if (flag_r[uerm_pkg::F_BUSY]) begin
            // Timer wrapped before the echo came back.
            flag_nxt = (flag_r & ~uerm_pkg::ABORT_MASK);
            flag_nxt[uerm_pkg::F_ERR] = 1'b1;
          end
        end
      end
      uerm_pkg::CMD_RISE: begin
        if (flag_r[uerm_pkg::F_BUSY] && !flag_r[uerm_pkg::F_ECHOHI]
            && !flag_r[uerm_pkg::F_ECHOLO]) begin
          flag_nxt[uerm_pkg::F_ECHOHI] = 1'b1;
          tick_nxt    = '0;
          ovf_cnt_nxt = '0;
        end else begin
          flag_nxt = flag_r & ~uerm_pkg::ABORT_MASK;
        end
      end
      uerm_pkg::CMD_FALL: begin
        if (running) begin
          lat_hi_nxt = range_sat[15:8];
          lat_lo_nxt = range_sat[7:0];
          flag_nxt   = '0;
          flag_nxt[uerm_pkg::F_NEW] = 1'b1;
        end else begin
          flag_nxt = flag_r & ~uerm_pkg::ABORT_MASK;
        end
      end
      uerm_pkg::CMD_TRIG: begin
        if (!flag_r[uerm_pkg::F_BUSY]) begin
          flag_nxt[uerm_pkg::F_BUSY]   = 1'b1;
          flag_nxt[uerm_pkg::F_ECHOHI] = 1'b0;
          flag_nxt[uerm_pkg::F_ECHOLO] = 1'b0;
          flag_nxt[uerm_pkg::F_OVF]    = 1'b0;
          flag_nxt[uerm_pkg::F_ERR]    = 1'b0;
          tick_nxt    = '0;
          ovf_cnt_nxt = '0;
          trig_nxt    = 1'b1;
        end
      end
      uerm_pkg::CMD_READ: begin
        read_valid_nxt = 1'b1;
      end
      uerm_pkg::CMD_ADC: begin
        ir_nxt = in_ch.adc_value;
      end
      default: begin
      end
    endcase
    // A read reports new-data as it was, then clears it.
    status_nxt = flag_nxt;
    if (read_valid_nxt) begin
      flag_nxt[uerm_pkg::F_NEW] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_limit_r  <= uerm_pkg::OVF_LIMIT_RST;
      scale_mult_r <= uerm_pkg::SCALE_MULT_RST;
      scale_shft_r <= uerm_pkg::SCALE_SHFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        uerm_pkg::REG_OVF_LIMIT:  ovf_limit_r  <= cfg_data;
        uerm_pkg::REG_SCALE_MULT: scale_mult_r <= cfg_data;
        uerm_pkg::REG_SCALE_SHFT: scale_shft_r <= cfg_data[uerm_pkg::SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r    <= '0;
      tick_r    <= '0;
      ovf_cnt_r <= '0;
      lat_hi_r  <= '0;
      lat_lo_r  <= '0;
      ir_r      <= '0;
    end else if (in_acc) begin
      flag_r    <= flag_nxt;
      tick_r    <= tick_nxt;
      ovf_cnt_r <= ovf_cnt_nxt;
      lat_hi_r  <= lat_hi_nxt;
      lat_lo_r  <= lat_lo_nxt;
      ir_r      <= ir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The latched range and infrared sample are read straight from the state registers,
  // which only change when the next item is accepted into the result register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r     <= status_nxt;
      read_valid_r <= read_valid_nxt;
      trig_r       <= trig_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.range_high     = lat_hi_r;
  assign out_ch.range_low      = lat_lo_r;
  assign out_ch.infrared_value = ir_r;
  assign out_ch.read_valid     = read_valid_r;
  assign out_ch.trigger_start  = trig_r;

`ifndef ASSERT_OFF
  a_trig_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.cmd == uerm_pkg::CMD_TRIG) && !flag_r[uerm_pkg::F_BUSY]
    |=> out_ch.valid && out_ch.trigger_start && out_ch.status[uerm_pkg::F_BUSY])
    else $error("trigger from idle did not start a measurement");

  a_read_clears_new: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.cmd == uerm_pkg::CMD_READ)
    |=> out_ch.read_valid && !flag_r[uerm_pkg::F_NEW])
    else $error("read did not answer or did not clear new-data");

  a_echo_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    flag_r[uerm_pkg::F_ECHOHI] |-> flag_r[uerm_pkg::F_BUSY])
    else $error("echo high flag set without a measurement in progress");

  a_fall_latches: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.cmd == uerm_pkg::CMD_FALL) && running
    |=> (flag_r == (SW'(1) << uerm_pkg::F_NEW)) && (lat_lo_r == $past(range_sat[7:0])))
    else $error("echo fall did not latch the scaled range");
`endif

endmodule
